@@ src/pce_pkg.sv @@
// shared types, constants and control structs of the palette crossfade engine
package pce_pkg;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 4;
    localparam int CHAN_W   = 5;
    localparam int NUM_CHAN = 3;
    localparam int COLOR_W  = CHAN_W * NUM_CHAN;
    localparam int STEP_W   = 6;
    localparam int ACC_W    = 11;

    localparam int DEF_PALETTE_ENTRIES = 16;
    localparam int DEF_FADE_STEPS      = 60;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] entry_color;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic [COLOR_W-1:0] out_color;
        logic               last_entry;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_TGT_WR,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_STEPS_LOAD,
        OP_STEPS_DEC,
        OP_SNAP_RD,
        OP_MUL1,
        OP_MUL2,
        OP_RECIP,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        ENT_HOLD,
        ENT_CLR,
        ENT_INC
    } ent_op_t;

    typedef struct packed {
        dp_op_t  op;
        ent_op_t ent;
    } ctrl_t;

    typedef struct packed {
        logic item_valid;
        logic mode_load;
        logic mode_start;
        logic tick_run;
        logic ent_last;
        logic out_busy;
    } status_t;

endpackage

@@ src/pce_sequencer.sv @@
// microcode step counter and control store of the palette crossfade engine
module pce_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  pce_pkg::status_t status,
    output pce_pkg::ctrl_t   ctrl
);
    import pce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DSP_LD,
        S_DSP_ST,
        S_DSP_TK,
        S_LOAD,
        S_ST_RD,
        S_ST_WR,
        S_ST_END,
        S_TICK,
        S_BL_RD,
        S_BL_M1,
        S_BL_M2,
        S_BL_RC,
        S_BL_EM,
        S_BL_NX
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ITEM_VALID,
        C_MODE_LOAD,
        C_MODE_START,
        C_TICK_RUN,
        C_LAST,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } ucode_t;

    function automatic ucode_t rom(step_t s);
        ucode_t w;
        w = '{ctrl: '{op: OP_NONE, ent: ENT_HOLD}, cond: C_ALWAYS,
              on_true: S_IDLE, on_false: S_IDLE};
        unique case (s)
            S_IDLE:   w = '{'{OP_ACCEPT, ENT_CLR}, C_ITEM_VALID, S_DSP_LD, S_IDLE};
            S_DSP_LD: w = '{'{OP_NONE, ENT_HOLD}, C_MODE_LOAD, S_LOAD, S_DSP_ST};
            S_DSP_ST: w = '{'{OP_NONE, ENT_HOLD}, C_MODE_START, S_ST_RD, S_DSP_TK};
            S_DSP_TK: w = '{'{OP_NONE, ENT_HOLD}, C_TICK_RUN, S_TICK, S_IDLE};
            S_LOAD:   w = '{'{OP_TGT_WR, ENT_HOLD}, C_ALWAYS, S_IDLE, S_IDLE};
            S_ST_RD:  w = '{'{OP_COPY_RD, ENT_HOLD}, C_ALWAYS, S_ST_WR, S_ST_WR};
            S_ST_WR:  w = '{'{OP_COPY_WR, ENT_INC}, C_LAST, S_ST_END, S_ST_RD};
            S_ST_END: w = '{'{OP_STEPS_LOAD, ENT_HOLD}, C_ALWAYS, S_IDLE, S_IDLE};
            S_TICK:   w = '{'{OP_STEPS_DEC, ENT_HOLD}, C_ALWAYS, S_BL_RD, S_BL_RD};
            S_BL_RD:  w = '{'{OP_SNAP_RD, ENT_HOLD}, C_ALWAYS, S_BL_M1, S_BL_M1};
            S_BL_M1:  w = '{'{OP_MUL1, ENT_HOLD}, C_ALWAYS, S_BL_M2, S_BL_M2};
            S_BL_M2:  w = '{'{OP_MUL2, ENT_HOLD}, C_ALWAYS, S_BL_RC, S_BL_RC};
            S_BL_RC:  w = '{'{OP_RECIP, ENT_HOLD}, C_ALWAYS, S_BL_EM, S_BL_EM};
            S_BL_EM:  w = '{'{OP_EMIT, ENT_HOLD}, C_OUT_BUSY, S_BL_EM, S_BL_NX};
            S_BL_NX:  w = '{'{OP_NONE, ENT_INC}, C_LAST, S_IDLE, S_BL_RD};
            default:  w = '{'{OP_NONE, ENT_HOLD}, C_ALWAYS, S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   cond_hit;

    assign word = rom(step_reg);
    assign ctrl = word.ctrl;

    always_comb
    begin
        unique case (word.cond)
            C_ALWAYS:     cond_hit = 1'b1;
            C_ITEM_VALID: cond_hit = status.item_valid;
            C_MODE_LOAD:  cond_hit = status.mode_load;
            C_MODE_START: cond_hit = status.mode_start;
            C_TICK_RUN:   cond_hit = status.tick_run;
            C_LAST:       cond_hit = status.ent_last;
            C_OUT_BUSY:   cond_hit = status.out_busy;
            default:      cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? word.on_true : word.on_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ src/pce_datapath.sv @@
// palette stores, channel blend arithmetic and result register
module pce_datapath #(
    parameter int PALETTE_ENTRIES = pce_pkg::DEF_PALETTE_ENTRIES,
    parameter int FADE_STEPS      = pce_pkg::DEF_FADE_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pce_pkg::ctrl_t   ctrl,
    output pce_pkg::status_t status,
    input  logic             item_valid,
    output logic             item_stall,
    input  pce_pkg::item_t   item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output pce_pkg::result_t result_data
);
    import pce_pkg::*;

    localparam int AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int EXT_W       = 8;
    localparam int RECIP_SHIFT = 12;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / FADE_STEPS;
    localparam int PROD_W      = ACC_W + RECIP_W;
    localparam int Q_W         = CHAN_W + 1;
    localparam int QL_W        = ACC_W + 1;

    localparam logic [STEP_W-1:0]  L_VAL    = STEP_W'(FADE_STEPS);
    localparam logic [RECIP_W-1:0] M_VAL    = RECIP_W'(RECIP_MUL);
    localparam logic [AW-1:0]      LAST_ENT = AW'(PALETTE_ENTRIES - 1);
    localparam logic [EXT_W-1:0]   N_ENT    = EXT_W'(PALETTE_ENTRIES);

    typedef struct packed {
        logic [COLOR_W-1:0] from_color;
        logic [COLOR_W-1:0] to_color;
    } snap_t;

    logic [COLOR_W-1:0] live_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] tgt_mem  [PALETTE_ENTRIES];
    snap_t              snap_mem [PALETTE_ENTRIES];

    logic [PALETTE_ENTRIES-1:0] live_vld_reg;
    logic [PALETTE_ENTRIES-1:0] tgt_vld_reg;
    logic [PALETTE_ENTRIES-1:0] snap_vld_reg;

    item_t              item_reg;
    logic [COLOR_W-1:0] live_rd_reg;
    logic [COLOR_W-1:0] tgt_rd_reg;
    snap_t              snap_rd_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [AW-1:0]      ent_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [NUM_CHAN-1:0][ACC_W-1:0] acc_reg;
    logic [NUM_CHAN-1:0][Q_W-1:0]   q_reg;

    logic [NUM_CHAN-1:0][ACC_W-1:0]  p_to;
    logic [NUM_CHAN-1:0][ACC_W-1:0]  p_from;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod;
    logic [NUM_CHAN-1:0][QL_W-1:0]   ql;
    logic [NUM_CHAN-1:0][QL_W-1:0]   rem;
    logic [NUM_CHAN-1:0][Q_W-1:0]    q_fix;
    logic [COLOR_W-1:0]              blend_color;

    logic [STEP_W-1:0] l_minus_t;
    logic [EXT_W-1:0]  idx_ext;
    logic [EXT_W-1:0]  ent_ext;
    logic [AW-1:0]     ld_addr;
    logic              ld_ok;
    logic              accept;
    logic              out_busy;
    logic              emit_fire;

    assign item_stall = (ctrl.op != OP_ACCEPT);
    assign accept     = item_valid && !item_stall;
    assign out_busy   = out_valid_reg && result_stall;
    assign emit_fire  = (ctrl.op == OP_EMIT) && !out_busy;

    assign idx_ext = {{(EXT_W - IDX_W){1'b0}}, item_reg.entry_index};
    assign ent_ext = {{(EXT_W - AW){1'b0}}, ent_reg};
    assign ld_addr = idx_ext[AW-1:0];
    assign ld_ok   = (idx_ext < N_ENT);

    assign l_minus_t = L_VAL - steps_reg;

    assign status.item_valid = item_valid;
    assign status.mode_load  = (item_reg.mode == MODE_LOAD);
    assign status.mode_start = (item_reg.mode == MODE_START);
    assign status.tick_run   = (item_reg.mode == MODE_TICK) && (steps_reg != '0);
    assign status.ent_last   = (ent_reg == LAST_ENT);
    assign status.out_busy   = out_busy;

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // three channel lanes
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            p_to[c]   = ACC_W'(snap_rd_reg.to_color[c*CHAN_W +: CHAN_W]) * ACC_W'(l_minus_t);
            p_from[c] = ACC_W'(snap_rd_reg.from_color[c*CHAN_W +: CHAN_W]) * ACC_W'(steps_reg);
            prod[c]   = PROD_W'(acc_reg[c]) * PROD_W'(M_VAL);
            ql[c]     = QL_W'(q_reg[c]) * QL_W'(L_VAL);
            rem[c]    = QL_W'(acc_reg[c]) - ql[c];
            q_fix[c]  = (rem[c] >= QL_W'(L_VAL)) ? (q_reg[c] + Q_W'(1)) : q_reg[c];
            blend_color[c*CHAN_W +: CHAN_W] = q_fix[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_vld_reg  <= '0;
            tgt_vld_reg   <= '0;
            snap_vld_reg  <= '0;
            steps_reg     <= '0;
            ent_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.ent)
                ENT_CLR:  ent_reg <= '0;
                ENT_INC:  ent_reg <= ent_reg + AW'(1);
                default:  ent_reg <= ent_reg;
            endcase
            if (ctrl.op == OP_TGT_WR && ld_ok)
            begin
                tgt_vld_reg[ld_addr] <= 1'b1;
            end
            if (ctrl.op == OP_COPY_WR)
            begin
                snap_vld_reg[ent_reg] <= 1'b1;
            end
            if (emit_fire)
            begin
                live_vld_reg[ent_reg] <= 1'b1;
            end
            if (ctrl.op == OP_STEPS_LOAD)
            begin
                steps_reg <= L_VAL;
            end
            else if (ctrl.op == OP_STEPS_DEC)
            begin
                steps_reg <= steps_reg - STEP_W'(1);
            end
            priority if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_data;
        end
        if (ctrl.op == OP_TGT_WR && ld_ok)
        begin
            tgt_mem[ld_addr] <= item_reg.entry_color;
        end
        if (ctrl.op == OP_COPY_RD)
        begin
            live_rd_reg <= live_vld_reg[ent_reg] ? live_mem[ent_reg] : '0;
            tgt_rd_reg  <= tgt_vld_reg[ent_reg] ? tgt_mem[ent_reg] : '0;
        end
        if (ctrl.op == OP_COPY_WR)
        begin
            snap_mem[ent_reg] <= '{from_color: live_rd_reg, to_color: tgt_rd_reg};
        end
        if (ctrl.op == OP_SNAP_RD)
        begin
            snap_rd_reg <= snap_vld_reg[ent_reg] ? snap_mem[ent_reg] : '0;
        end
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (ctrl.op == OP_MUL1)
            begin
                acc_reg[c] <= p_to[c];
            end
            else if (ctrl.op == OP_MUL2)
            begin
                acc_reg[c] <= acc_reg[c] + p_from[c];
            end
            if (ctrl.op == OP_RECIP)
            begin
                q_reg[c] <= prod[c][RECIP_SHIFT +: Q_W];
            end
        end
        if (emit_fire)
        begin
            live_mem[ent_reg] <= blend_color;
            out_reg.out_index  <= ent_ext[IDX_W-1:0];
            out_reg.out_color  <= blend_color;
            out_reg.last_entry <= (ent_reg == LAST_ENT);
        end
    end

endmodule

@@ src/palette_crossfade_engine.sv @@
// top level of the palette crossfade engine
// Usage:
//   item channel (item_valid, item_stall, item_data) takes one command beat:
//   load writes one target palette entry, start snapshots live and target
//   palettes and arms the fade counter, tick advances the fade one step.
//   result channel (result_valid, result_stall, result_data) carries one
//   beat per palette entry on each tick that blends, in ascending order,
//   with last_entry set on the final one.
// Sequencing:
//   each command is dispatched by the microcode sequencer; a blending
//   tick runs the six-step per-entry microcode loop (snapshot read, two
//   multiply steps, reciprocal divide, emit, next entry) through the shared
//   three-lane multiply and reciprocal divide.
//   the first result is registered at the emit step of the first entry.
// Reset:
//   all palettes read as zero and the fade counter is cleared.
// Stall:
//   a stalled result holds in the output register; the sequencer waits
//   on the emit step until it drains, and new items are taken only between
//   commands, while a finished result may still be waiting.
module palette_crossfade_engine #(
    parameter int PALETTE_ENTRIES = pce_pkg::DEF_PALETTE_ENTRIES,
    parameter int FADE_STEPS      = pce_pkg::DEF_FADE_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pce_pkg::item_t   item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output pce_pkg::result_t result_data
);
    import pce_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    pce_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    pce_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .FADE_STEPS      (FADE_STEPS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
